// ===== rtl/fmpd_pkg.sv =====
package fmpd_pkg;

   // Default and limit of the CORDIC iteration count
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int TABLE_LEN = 24;
   localparam int STEP_W = $clog2(TABLE_LEN);

   // Datapath widths
   localparam int SAMPLE_W = 16;
   localparam int PHASE_W = 16;
   localparam int GAIN_W = 16;
   localparam int ANGLE_W = 32;
   // Scaled sample (2^16) grows by the CORDIC gain; 35 bits covers it with margin
   localparam int XY_W = 35;
   localparam int PROD_W = PHASE_W + GAIN_W + 1;
   localparam int FRAC_W = 12;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] REG_GAIN = 1'b0;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

   // Half turn in accumulator units
   localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

   // Control from the sequencer to the CORDIC unit
   typedef struct packed {
      logic              load;
      logic              step;
      logic [STEP_W-1:0] idx;
   } cordic_ctl_type;

   // atan(2^-k) in units of 2^-32 turn
   function automatic logic [ANGLE_W-1:0] atan_step(input logic [STEP_W-1:0] k);
      logic [ANGLE_W-1:0] t;
      case (k)
         5'd0:    t = 32'd536870912;
         5'd1:    t = 32'd316933406;
         5'd2:    t = 32'd167458907;
         5'd3:    t = 32'd85004756;
         5'd4:    t = 32'd42667331;
         5'd5:    t = 32'd21354465;
         5'd6:    t = 32'd10679838;
         5'd7:    t = 32'd5340245;
         5'd8:    t = 32'd2670163;
         5'd9:    t = 32'd1335087;
         5'd10:   t = 32'd667544;
         5'd11:   t = 32'd333772;
         5'd12:   t = 32'd166886;
         5'd13:   t = 32'd83443;
         5'd14:   t = 32'd41722;
         5'd15:   t = 32'd20861;
         5'd16:   t = 32'd10430;
         5'd17:   t = 32'd5215;
         5'd18:   t = 32'd2608;
         5'd19:   t = 32'd1304;
         5'd20:   t = 32'd652;
         5'd21:   t = 32'd326;
         5'd22:   t = 32'd163;
         5'd23:   t = 32'd81;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

// ===== rtl/fmpd_cordic.sv =====
module fmpd_cordic (
   input  logic                                   clock,
   input  fmpd_pkg::cordic_ctl_type               ctl,
   input  logic signed [fmpd_pkg::SAMPLE_W-1:0]   i_sample,
   input  logic signed [fmpd_pkg::SAMPLE_W-1:0]   q_sample,
   output logic        [fmpd_pkg::PHASE_W-1:0]    phase
);

   logic signed [fmpd_pkg::XY_W-1:0]    x_ff, x_in;
   logic signed [fmpd_pkg::XY_W-1:0]    y_ff, y_in;
   logic        [fmpd_pkg::ANGLE_W-1:0] z_ff, z_in;
   logic                                zero_ff, zero_in;

   logic signed [fmpd_pkg::XY_W-1:0]    x_load, y_load;
   logic signed [fmpd_pkg::XY_W-1:0]    x_sh, y_sh;
   logic        [fmpd_pkg::ANGLE_W-1:0] t_k;

   // Scale the sample by 2^16
   assign x_load = fmpd_pkg::XY_W'(i_sample) <<< 16;
   assign y_load = fmpd_pkg::XY_W'(q_sample) <<< 16;

   // Shared shift unit, floor rounding
   assign x_sh = x_ff >>> ctl.idx;
   assign y_sh = y_ff >>> ctl.idx;
   assign t_k  = fmpd_pkg::atan_step(ctl.idx);

   // Load, pre-rotate by pi for the left half plane, or do one vectoring step
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      zero_in = zero_ff;
      if (ctl.load) begin
         zero_in = (i_sample == '0) && (q_sample == '0);
         if (i_sample[fmpd_pkg::SAMPLE_W-1]) begin
            x_in = -x_load;
            y_in = -y_load;
            z_in = fmpd_pkg::HALF_TURN;
         end else begin
            x_in = x_load;
            y_in = y_load;
            z_in = '0;
         end
      end else if (ctl.step) begin
         if (!y_ff[fmpd_pkg::XY_W-1]) begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + t_k;
         end else begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - t_k;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      zero_ff <= zero_in;
   end

   // Round the accumulator to the nearest 16-bit step; an all-zero sample gives phase 0
   assign phase = zero_ff ? '0
                : z_ff[fmpd_pkg::ANGLE_W-1 -: fmpd_pkg::PHASE_W]
                  + fmpd_pkg::PHASE_W'(z_ff[fmpd_pkg::PHASE_W-1]);

endmodule

// ===== rtl/fmpd_scale.sv =====
module fmpd_scale (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 mult_en,
   input  logic        [fmpd_pkg::PHASE_W-1:0]  phase,
   input  logic        [fmpd_pkg::GAIN_W-1:0]   gain,
   output logic signed [fmpd_pkg::PHASE_W-1:0]  demod,
   output logic                                 saturated
);

   localparam int SHIFT_W = fmpd_pkg::PROD_W - fmpd_pkg::FRAC_W;

   logic        [fmpd_pkg::PHASE_W-1:0] prev_phase_ff, prev_phase_in;
   logic signed [fmpd_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [fmpd_pkg::PHASE_W-1:0] diff;
   logic signed [SHIFT_W-1:0]           shifted;
   logic                                fits;

   // Wrapped phase difference times unsigned gain
   assign diff    = $signed(phase - prev_phase_ff);
   assign prod_in = mult_en ? fmpd_pkg::PROD_W'(diff * $signed({1'b0, gain})) : prod_ff;
   assign prev_phase_in = mult_en ? phase : prev_phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_phase_ff <= '0;
      end else begin
         prev_phase_ff <= prev_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Drop the fraction bits and clip to 16 bits
   assign shifted = prod_ff[fmpd_pkg::PROD_W-1:fmpd_pkg::FRAC_W];
   assign fits = (shifted[SHIFT_W-1:fmpd_pkg::PHASE_W-1] == '0)
              || (shifted[SHIFT_W-1:fmpd_pkg::PHASE_W-1] == '1);
   assign saturated = !fits;

   always_comb begin
      if (fits) begin
         demod = shifted[fmpd_pkg::PHASE_W-1:0];
      end else if (shifted[SHIFT_W-1]) begin
         demod = {1'b1, {(fmpd_pkg::PHASE_W-1){1'b0}}};
      end else begin
         demod = {1'b0, {(fmpd_pkg::PHASE_W-1){1'b1}}};
      end
   end

endmodule

// ===== rtl/fm_phase_discriminator.sv =====
// Each accepted request word gives one response word after these steps in order:
// load at the accepting edge, the CORDIC steps one by one in the shared shift-add unit,
// one multiply, one output register (which waits while the previous response is stalled).
// The single CORDIC unit takes one word at a time: req_stall stays high from the accepted
// word until its result is written to the output register and the sequencer is idle again.
// Reset (synchronous): stored phase 0, gain 4096 (unity), no response pending.
module fm_phase_discriminator #(
   parameter int CORDIC_STAGES = fmpd_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [fmpd_pkg::SAMPLE_W-1:0] req_i_sample,
   input  logic signed [fmpd_pkg::SAMPLE_W-1:0] req_q_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [fmpd_pkg::PHASE_W-1:0]  rsp_demod,
   output logic                                 rsp_saturated,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fmpd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [fmpd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [fmpd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   localparam int STAGES = (CORDIC_STAGES > fmpd_pkg::TABLE_LEN)
                         ? fmpd_pkg::TABLE_LEN : CORDIC_STAGES;
   localparam logic [fmpd_pkg::STEP_W-1:0] LAST_STEP = fmpd_pkg::STEP_W'(STAGES - 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_ITER = 4'b0010,
      S_MULT = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   logic [fmpd_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [fmpd_pkg::GAIN_W-1:0]        gain_ff, gain_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [fmpd_pkg::PHASE_W-1:0] rsp_demod_ff, rsp_demod_in;
   logic                               rsp_sat_ff, rsp_sat_in;

   fmpd_pkg::cordic_ctl_type           cordic_ctl;
   logic [fmpd_pkg::PHASE_W-1:0]       phase;
   logic signed [fmpd_pkg::PHASE_W-1:0] demod;
   logic                               saturated;
   logic                               req_take;
   logic                               out_free;
   logic                               mult_en;
   logic                               csr_wr;
   logic [0:0]                         csr_idx;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[fmpd_pkg::CSR_ADDR_W-1 -: 1];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign gain_in    = (csr_wr && csr_idx == fmpd_pkg::REG_GAIN)
                     ? csr_pwdata[fmpd_pkg::GAIN_W-1:0] : gain_ff;
   assign csr_prdata = (csr_idx == fmpd_pkg::REG_GAIN)
                     ? fmpd_pkg::CSR_DATA_W'(gain_ff) : '0;

   // Handshake
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !(rsp_valid_ff && rsp_stall);

   // Sequencer
   always_comb begin
      state_in         = state_ff;
      step_in          = step_ff;
      cordic_ctl.load  = 1'b0;
      cordic_ctl.step  = 1'b0;
      cordic_ctl.idx   = step_ff;
      mult_en          = 1'b0;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_demod_in     = rsp_demod_ff;
      rsp_sat_in       = rsp_sat_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cordic_ctl.load = 1'b1;
               step_in         = '0;
               state_in        = S_ITER;
            end
         end
         S_ITER: begin
            cordic_ctl.step = 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = S_MULT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_MULT: begin
            mult_en  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_demod_in = demod;
               rsp_sat_in   = saturated;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gain_ff      <= fmpd_pkg::GAIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      rsp_demod_ff <= rsp_demod_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   fmpd_cordic u_cordic (
      .clock    (clock),
      .ctl      (cordic_ctl),
      .i_sample (req_i_sample),
      .q_sample (req_q_sample),
      .phase    (phase)
   );

   fmpd_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .mult_en   (mult_en),
      .phase     (phase),
      .gain      (gain_ff),
      .demod     (demod),
      .saturated (saturated)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_demod     = rsp_demod_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule
